@@ rtl/tph_pkg.sv @@
// tph_pkg: shared constants and types for the ttl pending hash table
// no dependencies; imported by the table top level
`default_nettype none

package tph_pkg;

  // table geometry
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_RAW = $clog2(ENTRIES + 1);
  localparam int unsigned CNT_W   = (CNT_RAW > 9) ? CNT_RAW : 9;

  // field widths
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned KEY_W   = 256;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned TTL_W   = 32;
  localparam int unsigned LCNT_W  = 9;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ENTRY_W = KEY_W + STAMP_W;

  localparam logic [TTL_W-1:0] TTL_RESET = 32'd3600;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

@@ rtl/tph_ram.sv @@
// tph_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                           clk_i,
  input  wire                                           we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                              wdata_i,
  input  wire                                           re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ttl_pending_hash_table_top.sv @@
// ttl_pending_hash_table_top: 256-bit keys with timestamps, expiry by ttl, add/query/remove
// depends on tph_pkg and tph_ram
// sequence: accept in idle, scan every entry at one ram read a cycle, insert in ST_FIN, then wait in ST_RESP
// until the result side is free; a new request is taken only after the result is loaded and idle returns
// reset: valid marks, live count and control clear at once; ttl returns to 3600
`default_nettype none

module ttl_pending_hash_table_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // ttl register write
  input  wire                             cfg_we_i,
  input  wire  [tph_pkg::TTL_W-1:0]       cfg_wdata_i,
  // request channel
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [tph_pkg::REQ_W-1:0]       req_type_i,
  input  wire  [tph_pkg::WORD_W-1:0]      hash_word0_i,
  input  wire  [tph_pkg::WORD_W-1:0]      hash_word1_i,
  input  wire  [tph_pkg::WORD_W-1:0]      hash_word2_i,
  input  wire  [tph_pkg::WORD_W-1:0]      hash_word3_i,
  input  wire  [tph_pkg::STAMP_W-1:0]     now_time_i,
  // result channel
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            hit_o,
  output logic                            full_drop_o,
  output logic [tph_pkg::LCNT_W-1:0]      live_count_o
);

  import tph_pkg::*;

  // ttl register
  logic [TTL_W-1:0] ttl_q;

  // latched request
  logic [REQ_W-1:0]   req_q;
  logic [KEY_W-1:0]   key_q;
  logic [STAMP_W-1:0] now_q;

  // sequencer state
  state_e           state_q, state_d;
  logic             iss_q, iss_d;         // read issue still running
  logic [IDX_W-1:0] iss_idx_q, iss_idx_d; // address being read
  logic             pv_q, pv_d;           // read data valid this cycle
  logic [IDX_W-1:0] pidx_q, pidx_d;       // index of the read data
  logic             hit_q, hit_d;
  logic             found_q, found_d;     // a free slot has been seen
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;         // number of set valid marks

  // valid marks, one flop per entry
  logic [ENTRIES-1:0] valid_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;
  logic              out_drop_q;
  logic [LCNT_W-1:0] out_cnt_q;
  logic              out_load;

  // entry memory: {key, stamp}
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  // scan datapath
  logic [KEY_W-1:0]   ent_key;
  logic [STAMP_W-1:0] ent_stamp;
  logic [STAMP_W-1:0] ent_age;
  logic               ent_v, ent_expired, ent_match, ent_live;
  logic               is_add, is_remove;
  logic               clr_scan, refresh, insert;
  logic               accept;

  tph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign is_add    = (req_q == REQ_ADD);
  assign is_remove = (req_q == REQ_REMOVE);

  // compare stage on the entry just read
  assign ent_key     = ram_rdata[ENTRY_W-1:STAMP_W];
  assign ent_stamp   = ram_rdata[STAMP_W-1:0];
  assign ent_age     = now_q - ent_stamp;            // wraps modulo 2^64
  assign ent_expired = ent_age > STAMP_W'(ttl_q);
  assign ent_match   = (ent_key == key_q);
  assign ent_v       = valid_q[pidx_q];
  assign ent_live    = ent_v && !ent_expired;

  // expired entries drop on add and remove; live matches drop on remove
  assign clr_scan = pv_q && (is_add || is_remove) && ent_v &&
                    (ent_expired || (ent_match && is_remove));
  // live match on add gets a fresh stamp
  assign refresh  = pv_q && is_add && ent_live && ent_match;
  // new key goes to the lowest free slot after the scan
  assign insert   = (state_q == ST_FIN) && is_add && !hit_q && found_q;

  assign ram_re    = (state_q == ST_SCAN) && iss_q;
  assign ram_we    = refresh || insert;
  assign ram_waddr = insert ? free_idx_q : pidx_q;
  assign ram_wdata = {key_q, now_q};  // a refreshed entry already holds this key

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    iss_idx_d   = iss_idx_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    hit_d       = hit_q;
    found_d     = found_q;
    free_idx_d  = free_idx_q;
    drop_d      = drop_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_SCAN;
          iss_d     = 1'b1;
          iss_idx_d = '0;
          hit_d     = 1'b0;
          found_d   = 1'b0;
          drop_d    = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue side
        if (iss_q) begin
          pv_d   = 1'b1;
          pidx_d = iss_idx_q;
          if (iss_idx_q == IDX_W'(ENTRIES - 1)) begin
            iss_d = 1'b0;
          end else begin
            iss_idx_d = iss_idx_q + 1'b1;
          end
        end
        // compare side
        if (pv_q) begin
          if (ent_live && ent_match) begin
            hit_d = 1'b1;
          end
          if (clr_scan) begin
            cnt_d = cnt_q - 1'b1;
          end
          if (!found_q && (!ent_v || clr_scan)) begin
            found_d    = 1'b1;
            free_idx_d = pidx_q;
          end
        end
        if (!iss_q && !pv_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (insert) begin
          cnt_d = cnt_q + 1'b1;
        end
        drop_d  = is_add && !hit_q && !found_q;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= 1'b0;
      pv_q        <= 1'b0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      drop_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ttl_q       <= TTL_RESET;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      pv_q        <= pv_d;
      hit_q       <= hit_d;
      found_q     <= found_d;
      drop_q      <= drop_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
    end
  end

  // valid marks: cleared during the scan, set by an insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (clr_scan) begin
        valid_q[pidx_q] <= 1'b0;
      end
      if (insert) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    iss_idx_q  <= iss_idx_d;
    pidx_q     <= pidx_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      req_q <= req_type_i;
      key_q <= {hash_word3_i, hash_word2_i, hash_word1_i, hash_word0_i};
      now_q <= now_time_i;
    end
    if (out_load) begin
      out_hit_q  <= hit_q;
      out_drop_q <= drop_q;
      out_cnt_q  <= cnt_q[LCNT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign full_drop_o  = out_drop_q;
  assign live_count_o = out_cnt_q;

  // live count tracks the valid marks
  a_cnt_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(valid_q)))
    else $error("live count differs from valid marks");

  // entry memory is written only while a request is in progress
  a_we_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SCAN || state_q == ST_FIN))
    else $error("entry write outside scan");

  // an add that hit never reports a drop
  a_hit_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_drop_q))
    else $error("hit and drop both set");

  // a new request is never taken while read data is in flight
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q || iss_q) |-> !in_ready_o)
    else $error("request accepted during scan");

endmodule

`default_nettype wire
